@@ rtl/bdc_pkg.sv @@
package bdc_pkg;

	typedef logic [1:0] func_t;

	localparam func_t FN_SET   = 2'd0;
	localparam func_t FN_UNSET = 2'd1;
	localparam func_t FN_CLEAR = 2'd2;
	localparam func_t FN_READ  = 2'd3;

	localparam logic [15:0] BRAILLE_BASE = 16'h2800;
	localparam logic [7:0]  LEAD3_MARK   = 8'hE0;
	localparam logic [7:0]  CONT_MARK    = 8'h80;
	localparam logic [5:0]  CONT_MASK    = 6'h3F;
	localparam logic [7:0]  SPACE_BYTE   = 8'h20;
	localparam logic [7:0]  NEWLINE_BYTE = 8'h0A;
	localparam logic [23:0] WHITE        = 24'hFFFFFF;

	typedef logic [2:0] dot_idx_t;

	function automatic dot_idx_t dot_bit(input logic dx, input logic [1:0] dy);
		dot_idx_t r;
		case (dy)
			2'd0: r = dx ? 3'd3 : 3'd0;
			2'd1: r = dx ? 3'd4 : 3'd1;
			2'd2: r = dx ? 3'd5 : 3'd2;
			2'd3: r = dx ? 3'd7 : 3'd6;
			default: r = 3'd0;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/bdc_ram.sv @@
module bdc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

@@ rtl/braille_dot_canvas_unit.sv @@
// A set or unset item reads the cell and writes it back with the dot changed; a clear item
// zeroes one cell of the store per cycle. A read item reads the cell, then the color of its
// first lit dot, then gives one output byte per cycle (1 to 4 bytes); results leave on strobe
// and cannot be stalled. Items are handled one at a time. After reset the
// (MAX_WIDTH+1)/2 * (MAX_HEIGHT+3)/4 cells of the cell store (4096 at the defaults) are
// zeroed while busy is high; size registers reset to the maximum size, capped at 511 x 255.
module braille_dot_canvas_unit #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 128
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	input  logic                 start,
	output logic                 busy,
	input  bdc_pkg::func_t       func,
	input  logic [8:0]           pixel_x,
	input  logic [7:0]           pixel_y,
	input  logic [23:0]          pixel_color,
	input  logic [6:0]           cell_col,
	input  logic [4:0]           cell_row,
	output logic                 strobe,
	output logic [7:0]           out_byte,
	output logic [23:0]          dot_color,
	output logic                 last
);
	import bdc_pkg::*;

	localparam int CELLS_W    = (MAX_WIDTH + 1) / 2;
	localparam int CELLS_H    = (MAX_HEIGHT + 3) / 4;
	localparam int CELL_DEPTH = CELLS_W * CELLS_H;
	localparam int PIX_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int CELL_AW    = $clog2(CELL_DEPTH);
	localparam int PIX_AW     = $clog2(PIX_DEPTH);
	localparam int RST_W      = (MAX_WIDTH > 511) ? 511 : MAX_WIDTH;
	localparam int RST_H      = (MAX_HEIGHT > 255) ? 255 : MAX_HEIGHT;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CLR  = 4'd1;
	localparam logic [3:0] S_ADDR = 4'd2;
	localparam logic [3:0] S_RD   = 4'd3;
	localparam logic [3:0] S_MOD  = 4'd4;
	localparam logic [3:0] S_PIX  = 4'd5;
	localparam logic [3:0] S_CRD  = 4'd6;
	localparam logic [3:0] S_CWT  = 4'd7;
	localparam logic [3:0] S_EMIT = 4'd8;

	logic [3:0]         state_q;
	logic [CELL_AW-1:0] clr_q;
	logic [8:0]         width_q;
	logic [7:0]         height_q;

	func_t              func_q;
	logic [8:0]         x_q;
	logic [7:0]         y_q;
	logic [23:0]        color_q;
	logic [6:0]         cc_q;
	logic [4:0]         cr_q;
	logic [CELL_AW-1:0] ci_q;
	logic [PIX_AW-1:0]  pi_q;
	logic [7:0]         mask_q;
	logic               found_q;
	logic               dx_q;
	logic [1:0]         dy_q;
	logic [23:0]        dcol_q;
	logic [1:0]         idx_q;

	logic               strobe_q;
	logic [7:0]         byte_q;
	logic [23:0]        ocol_q;
	logic               last_q;

	logic [9:0]         cw_sum;
	logic [9:0]         ch_sum;
	logic [8:0]         cw;
	logic [7:0]         ch;
	logic               is_rw;
	logic               in_range;
	logic [19:0]        ci_full;
	logic [19:0]        pi_full;
	logic [19:0]        pir_full;
	logic               eol;

	logic               cfg_wr;
	logic [8:0]         wv;
	logic [7:0]         hv;

	logic               cell_we;
	logic [CELL_AW-1:0] cell_waddr;
	logic [7:0]         cell_wdata;
	logic [7:0]         cell_rdata;
	logic [7:0]         dot_mask;
	logic               color_we;
	logic [23:0]        color_wdata;
	logic [23:0]        color_rdata;

	logic               hit_any;
	logic               hit_dx;
	logic [1:0]         hit_dy;

	logic               blank;
	logic [1:0]         data_last;
	logic [15:0]        cp;
	logic [7:0]         e_byte;
	logic [23:0]        e_col;
	logic               e_last;

	assign pready = 1'b1;
	assign busy   = (state_q != S_IDLE);
	assign strobe = strobe_q;
	assign out_byte  = byte_q;
	assign dot_color = ocol_q;
	assign last      = last_q;

	assign prdata = paddr[2] ? {24'd0, height_q} : {23'd0, width_q};

	assign cfg_wr = psel && penable && pwrite && pready;
	assign wv = pwdata[8:0];
	assign hv = pwdata[7:0];

	assign cw_sum = {1'b0, width_q} + 10'd1;
	assign cw     = cw_sum[9:1];
	assign ch_sum = {2'd0, height_q} + 10'd3;
	assign ch     = ch_sum[9:2];
	assign eol    = ({2'd0, cc_q} + 9'd1) == cw;
	assign is_rw  = (func_q == FN_SET) || (func_q == FN_UNSET);

	always_comb begin
		if (is_rw) begin
			in_range = (x_q < width_q) && (y_q < height_q);
			ci_full  = 20'(y_q[7:2]) * 20'(cw) + 20'(x_q[8:1]);
		end else begin
			in_range = ({2'd0, cc_q} < cw) && ({3'd0, cr_q} < ch);
			ci_full  = 20'(cr_q) * 20'(cw) + 20'(cc_q);
		end
		pi_full  = 20'(y_q) * 20'(width_q) + 20'(x_q);
		pir_full = 20'({cr_q, dy_q}) * 20'(width_q) + 20'({cc_q, dx_q});
	end

	always_comb begin
		logic dx;
		logic [1:0] dy;
		hit_any = 1'b0;
		hit_dx  = 1'b0;
		hit_dy  = 2'd0;
		for (int k = 7; k >= 0; k--) begin
			dx = 1'(k);
			dy = 2'(k >> 1);
			if (cell_rdata[dot_bit(dx, dy)] && ({1'b0, cc_q, dx} < width_q)
					&& ({1'b0, cr_q, dy} < height_q)) begin
				hit_any = 1'b1;
				hit_dx  = dx;
				hit_dy  = dy;
			end
		end
	end

	assign dot_mask = 8'd1 << dot_bit(x_q[0], y_q[1:0]);

	always_comb begin
		cell_we    = 1'b0;
		cell_waddr = ci_q;
		cell_wdata = 8'd0;
		if (state_q == S_CLR) begin
			cell_we    = 1'b1;
			cell_waddr = clr_q;
		end else if (state_q == S_MOD && is_rw) begin
			cell_we    = 1'b1;
			cell_wdata = (func_q == FN_SET) ? (cell_rdata | dot_mask)
				: (cell_rdata & ~dot_mask);
		end
	end

	assign color_we    = (state_q == S_MOD) && is_rw;
	assign color_wdata = (func_q == FN_SET) ? color_q : 24'd0;

	bdc_ram #(.WIDTH(8), .DEPTH(CELL_DEPTH)) u_cell_ram (
		.clk   (clk),
		.we    (cell_we),
		.waddr (cell_waddr),
		.wdata (cell_wdata),
		.re    (state_q == S_RD),
		.raddr (ci_q),
		.rdata (cell_rdata)
	);

	bdc_ram #(.WIDTH(24), .DEPTH(PIX_DEPTH)) u_color_ram (
		.clk   (clk),
		.we    (color_we),
		.waddr (pi_q),
		.wdata (color_wdata),
		.re    (state_q == S_CRD),
		.raddr (pi_q),
		.rdata (color_rdata)
	);

	assign blank     = (mask_q == 8'd0);
	assign data_last = blank ? 2'd0 : 2'd2;
	assign cp        = BRAILLE_BASE + {8'd0, mask_q};

	always_comb begin
		if (idx_q <= data_last) begin
			e_col  = blank ? WHITE : dcol_q;
			e_last = (idx_q == data_last) && !eol;
			case (idx_q)
				2'd0: e_byte = blank ? SPACE_BYTE : (LEAD3_MARK | {4'd0, cp[15:12]});
				2'd1: e_byte = CONT_MARK | {2'd0, cp[11:6] & CONT_MASK};
				default: e_byte = CONT_MARK | {2'd0, cp[5:0] & CONT_MASK};
			endcase
		end else begin
			e_byte = NEWLINE_BYTE;
			e_col  = WHITE;
			e_last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 9'(RST_W);
			height_q <= 8'(RST_H);
		end else if (cfg_wr) begin
			if (!paddr[2]) begin
				if (wv == 9'd0) begin
					width_q <= 9'd1;
				end else if (32'(wv) > MAX_WIDTH) begin
					width_q <= 9'(MAX_WIDTH);
				end else begin
					width_q <= wv;
				end
			end else begin
				if (hv == 8'd0) begin
					height_q <= 8'd1;
				end else if (32'(hv) > MAX_HEIGHT) begin
					height_q <= 8'(MAX_HEIGHT);
				end else begin
					height_q <= hv;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			clr_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						clr_q   <= '0;
						state_q <= (func == FN_CLEAR) ? S_CLR : S_ADDR;
					end
				end
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CELL_AW'(CELL_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_ADDR: begin
					state_q <= in_range ? S_RD : S_IDLE;
				end
				S_RD: begin
					state_q <= S_MOD;
				end
				S_MOD: begin
					state_q <= is_rw ? S_IDLE : S_PIX;
				end
				S_PIX: begin
					state_q <= S_CRD;
				end
				S_CRD: begin
					state_q <= S_CWT;
				end
				S_CWT: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					strobe_q <= 1'b1;
					if (e_last) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			func_q  <= func;
			x_q     <= pixel_x;
			y_q     <= pixel_y;
			color_q <= pixel_color;
			cc_q    <= cell_col;
			cr_q    <= cell_row;
		end
		if (state_q == S_ADDR) begin
			ci_q <= ci_full[CELL_AW-1:0];
			pi_q <= pi_full[PIX_AW-1:0];
		end
		if (state_q == S_MOD) begin
			mask_q  <= cell_rdata;
			found_q <= hit_any;
			dx_q    <= hit_dx;
			dy_q    <= hit_dy;
		end
		if (state_q == S_PIX) begin
			pi_q <= pir_full[PIX_AW-1:0];
		end
		if (state_q == S_CWT) begin
			dcol_q <= found_q ? color_rdata : WHITE;
			idx_q  <= 2'd0;
		end
		if (state_q == S_EMIT) begin
			idx_q  <= idx_q + 2'd1;
			byte_q <= e_byte;
			ocol_q <= e_col;
			last_q <= e_last;
		end
	end
endmodule
